// ----- rtl/core/ftma_pkg.sv -----
// Shared types and constants of the frame timer moving average block.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
`default_nettype none

package ftma_pkg;

    localparam int TIME_W     = 40;   // frame time width in ns, saturating
    localparam int TICK_W     = 64;
    localparam int PERIOD_W   = 32;   // Q16.16 tick period
    localparam int FRAC_W     = 16;
    localparam int CNT_W      = 7;    // window length and sample count
    localparam int FIF_W      = 4;
    localparam int IDX_W      = 3;
    localparam int QS_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int SUM_W      = TIME_W + CNT_W;
    localparam int CONV_W     = TIME_W + 10;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int Q_DEPTH    = 2;
    localparam int QP_W       = 1;
    localparam int QC_W       = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_MARKED    = 3'd0,
        ST_SAMPLE    = 3'd1,
        ST_UNWRITTEN = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_FAILED    = 3'd4,
        ST_BAD_INDEX = 3'd5
    } status_t;

    typedef enum logic {
        CMD_MARK = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [QS_W-1:0] {
        QS_READY     = 2'd0,
        QS_NOT_READY = 2'd1,
        QS_FAILED    = 2'd2
    } query_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAMES = 2'd0,
        CFG_WINDOW = 2'd1,
        CFG_PERIOD = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_CONV,
        B_PUSH,
        B_DIV,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        status_t           status;
        logic [TICK_W-1:0] delta;
    } q_item_t;

    typedef struct packed {
        logic [FIF_W-1:0]    fif;
        logic [CNT_W-1:0]    window;
        logic [PERIOD_W-1:0] period;
        logic                window_clear;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/ftma_req_if.sv -----
// Command channel of the frame timer: valid/ready plus one command transaction.
// Depends on ftma_pkg for field widths.
`default_nettype none

interface ftma_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ftma_pkg::IDX_W-1:0]    frame_index;
    logic [ftma_pkg::TICK_W-1:0]   start_ticks;
    logic [ftma_pkg::TICK_W-1:0]   end_ticks;
    logic [ftma_pkg::QS_W-1:0]     query_state;

    modport source (output valid, cmd, frame_index, start_ticks, end_ticks, query_state,
                    input ready);
    modport sink   (input valid, cmd, frame_index, start_ticks, end_ticks, query_state,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ftma_rsp_if.sv -----
// Result channel of the frame timer: valid/ready plus one result transaction.
// Depends on ftma_pkg for field widths.
`default_nettype none

interface ftma_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ftma_pkg::STATUS_W-1:0]   status;
    logic [ftma_pkg::TIME_W-1:0]     frame_time_ns;
    logic [ftma_pkg::TIME_W-1:0]     average_ns;
    logic [ftma_pkg::CNT_W-1:0]      sample_count;

    modport source (output valid, status, frame_time_ns, average_ns, sample_count,
                    input ready);
    modport sink   (input valid, status, frame_time_ns, average_ns, sample_count,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ftma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ftma_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/ftma_queue.sv -----
// Two-entry queue of classified commands between the front and back parts.
// Depends on ftma_pkg for the queue item type.
`default_nettype none

module ftma_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire ftma_pkg::q_item_t push_item,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output ftma_pkg::q_item_t      pop_item
);

    ftma_pkg::q_item_t              entry_reg [ftma_pkg::Q_DEPTH];
    logic [ftma_pkg::QP_W-1:0]      wr_ptr_reg;
    logic [ftma_pkg::QP_W-1:0]      wr_ptr_next;
    logic [ftma_pkg::QP_W-1:0]      rd_ptr_reg;
    logic [ftma_pkg::QP_W-1:0]      rd_ptr_next;
    logic [ftma_pkg::QC_W-1:0]      count_reg;
    logic [ftma_pkg::QC_W-1:0]      count_next;
    logic                           push;
    logic                           pop;

    assign push_ready = (count_reg != ftma_pkg::QC_W'(ftma_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ftma_pkg::QC_W'(ftma_pkg::Q_DEPTH))
        else $error("queue holds more than its depth");

endmodule

`default_nettype wire

// ----- rtl/core/ftma_front.sv -----
// Front part: accepts commands, keeps the per-slot written flags and classifies
// each transaction into a status and tick delta. Depends on ftma_pkg, ftma_req_if.
`default_nettype none

module ftma_front #(
    parameter int MAX_FRAMES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ftma_req_if.sink               req,
    input  wire ftma_pkg::cfg_t    cfg,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output ftma_pkg::q_item_t      push_item
);

    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [MAX_FRAMES-1:0]  flag_reg;
    logic [MAX_FRAMES-1:0]  flag_next;
    logic [FIDX_W-1:0]      fidx;
    logic                   index_ok;
    logic                   accept;
    ftma_pkg::status_t      status_c;

    assign fidx     = FIDX_W'(req.frame_index);
    assign index_ok = ({1'b0, req.frame_index} < cfg.fif)
                   && (32'(req.frame_index) < 32'(MAX_FRAMES));
    assign accept   = req.valid && push_ready;

    always_comb
    begin
        if (!index_ok)
        begin
            status_c = ftma_pkg::ST_BAD_INDEX;
        end
        else if (req.cmd == ftma_pkg::CMD_MARK)
        begin
            status_c = ftma_pkg::ST_MARKED;
        end
        else if (!flag_reg[fidx])
        begin
            status_c = ftma_pkg::ST_UNWRITTEN;
        end
        else
        begin
            case (req.query_state)
                ftma_pkg::QS_READY:     status_c = ftma_pkg::ST_SAMPLE;
                ftma_pkg::QS_NOT_READY: status_c = ftma_pkg::ST_NOT_READY;
                default:                status_c = ftma_pkg::ST_FAILED;
            endcase
        end
    end

    always_comb
    begin
        flag_next = flag_reg;
        if (accept && status_c == ftma_pkg::ST_MARKED)
        begin
            flag_next[fidx] = 1'b1;
        end
        else if (accept && status_c == ftma_pkg::ST_SAMPLE)
        begin
            flag_next[fidx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign req.ready        = push_ready;
    assign push_valid       = req.valid;
    assign push_item.status = status_c;
    // wraps modulo 2^64 when the end stamp is behind the start stamp
    assign push_item.delta  = req.end_ticks - req.start_ticks;

    a_mark_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_c == ftma_pkg::ST_MARKED) |=> flag_reg[$past(fidx)])
        else $error("marked slot flag not set");

endmodule

`default_nettype wire

// ----- rtl/core/ftma_back.sv -----
// Back part: tick-to-ns conversion on a shared 32x32 multiplier, sample ring with
// running sum, serial divider for the average and the result register.
// Depends on ftma_pkg, ftma_rsp_if and ftma_ram.
`default_nettype none

module ftma_back #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ftma_pkg::cfg_t    cfg,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire ftma_pkg::q_item_t pop_item,
    ftma_rsp_if.source             rsp
);

    localparam int RIDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW     = ((RIDX_W > ftma_pkg::CNT_W) ? RIDX_W : ftma_pkg::CNT_W) + 1;
    localparam int HI_W   = ftma_pkg::TIME_W - ftma_pkg::FRAC_W;

    ftma_pkg::back_state_t              state_reg;
    ftma_pkg::back_state_t              state_next;
    ftma_pkg::status_t                  status_reg;
    ftma_pkg::status_t                  status_next;
    logic [ftma_pkg::TICK_W-1:0]        delta_reg;
    logic [ftma_pkg::TICK_W-1:0]        delta_next;
    logic [2*ftma_pkg::PERIOD_W-1:0]    plo_reg;
    logic [2*ftma_pkg::PERIOD_W-1:0]    plo_next;
    logic [2*ftma_pkg::PERIOD_W-1:0]    phi_reg;
    logic [2*ftma_pkg::PERIOD_W-1:0]    phi_next;
    logic [ftma_pkg::TIME_W-1:0]        last_time_reg;
    logic [ftma_pkg::TIME_W-1:0]        last_time_next;
    logic [ftma_pkg::SUM_W-1:0]         sum_reg;
    logic [ftma_pkg::SUM_W-1:0]         sum_next;
    logic [ftma_pkg::CNT_W-1:0]         count_reg;
    logic [ftma_pkg::CNT_W-1:0]         count_next;
    logic [RIDX_W-1:0]                  slot_reg;
    logic [RIDX_W-1:0]                  slot_next;
    logic [ftma_pkg::TIME_W-1:0]        avg_reg;
    logic [ftma_pkg::TIME_W-1:0]        avg_next;
    logic [ftma_pkg::SUM_W-1:0]         div_reg;
    logic [ftma_pkg::SUM_W-1:0]         div_next;
    logic [ftma_pkg::CNT_W-1:0]         rem_reg;
    logic [ftma_pkg::CNT_W-1:0]         rem_next;
    logic [ftma_pkg::DIV_CNT_W-1:0]     div_cnt_reg;
    logic [ftma_pkg::DIV_CNT_W-1:0]     div_cnt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    ftma_pkg::status_t                  out_status_reg;
    logic [ftma_pkg::TIME_W-1:0]        out_time_reg;
    logic [ftma_pkg::TIME_W-1:0]        out_avg_reg;
    logic [ftma_pkg::CNT_W-1:0]         out_count_reg;

    logic                               pop;
    logic                               out_load;
    logic                               ring_we;
    logic                               div_last;
    logic                               window_full;
    logic [ftma_pkg::PERIOD_W-1:0]      mul_a;
    logic [2*ftma_pkg::PERIOD_W-1:0]    mul_p;
    logic                               conv_sat;
    logic [ftma_pkg::CONV_W-1:0]        conv_sum;
    logic [ftma_pkg::TIME_W-1:0]        conv_ns;
    logic [ftma_pkg::TIME_W-1:0]        ring_rdata;
    logic [ftma_pkg::TIME_W-1:0]        evict;
    logic [NW-1:0]                      slot_inc;
    logic [ftma_pkg::CNT_W:0]           rem_sh;
    logic                               rem_ge;

    ftma_ram #(
        .WIDTH (ftma_pkg::TIME_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (last_time_reg),
        .raddr (slot_reg),
        .rdata (ring_rdata)
    );

    assign window_full = (count_reg == cfg.window);
    assign div_last    = (div_cnt_reg == ftma_pkg::DIV_CNT_W'(ftma_pkg::SUM_W - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ftma_pkg::B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = (pop_item.status == ftma_pkg::ST_SAMPLE)
                               ? ftma_pkg::B_MUL_LO : ftma_pkg::B_EMIT;
                end
            end
            ftma_pkg::B_MUL_LO: state_next = ftma_pkg::B_MUL_HI;
            ftma_pkg::B_MUL_HI: state_next = ftma_pkg::B_CONV;
            ftma_pkg::B_CONV:   state_next = ftma_pkg::B_PUSH;
            ftma_pkg::B_PUSH:   state_next = ftma_pkg::B_DIV;
            ftma_pkg::B_DIV:
            begin
                if (div_last)
                begin
                    state_next = ftma_pkg::B_EMIT;
                end
            end
            ftma_pkg::B_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ftma_pkg::B_IDLE;
                end
            end
            default:            state_next = ftma_pkg::B_IDLE;
        endcase
    end

    // control decode
    always_comb
    begin
        pop      = 1'b0;
        ring_we  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ftma_pkg::B_IDLE: pop      = pop_valid;
            ftma_pkg::B_PUSH: ring_we  = 1'b1;
            ftma_pkg::B_EMIT: out_load = !out_valid_reg || rsp.ready;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign pop_ready = pop;

    // one shared multiplier, low half of the delta first
    assign mul_a = (state_reg == ftma_pkg::B_MUL_LO) ? delta_reg[ftma_pkg::PERIOD_W-1:0]
                                                     : delta_reg[ftma_pkg::TICK_W-1:ftma_pkg::PERIOD_W];
    assign mul_p = mul_a * cfg.period;

    // round to nearest, halves up, then saturate
    assign conv_sat = |phi_reg[2*ftma_pkg::PERIOD_W-1:HI_W];
    assign conv_sum = ftma_pkg::CONV_W'({phi_reg[HI_W-1:0], {ftma_pkg::FRAC_W{1'b0}}})
                    + ftma_pkg::CONV_W'(plo_reg[2*ftma_pkg::PERIOD_W-1:ftma_pkg::FRAC_W])
                    + ftma_pkg::CONV_W'(plo_reg[ftma_pkg::FRAC_W-1]);
    assign conv_ns  = (conv_sat || conv_sum > ftma_pkg::CONV_W'(ftma_pkg::TIME_MAX))
                    ? ftma_pkg::TIME_MAX : conv_sum[ftma_pkg::TIME_W-1:0];

    assign evict    = window_full ? ring_rdata : '0;
    assign slot_inc = NW'(slot_reg) + 1'b1;

    // restoring division, one quotient bit a cycle
    assign rem_sh = {rem_reg, div_reg[ftma_pkg::SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, count_reg});

    always_comb
    begin
        status_next    = status_reg;
        delta_next     = delta_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        last_time_next = last_time_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        avg_next       = avg_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

        case (state_reg)
            ftma_pkg::B_IDLE:
            begin
                if (pop)
                begin
                    status_next = pop_item.status;
                    delta_next  = pop_item.delta;
                end
            end
            ftma_pkg::B_MUL_LO: plo_next = mul_p;
            ftma_pkg::B_MUL_HI: phi_next = mul_p;
            ftma_pkg::B_CONV:   last_time_next = conv_ns;
            ftma_pkg::B_PUSH:
            begin
                sum_next = sum_reg + ftma_pkg::SUM_W'(last_time_reg)
                         - ftma_pkg::SUM_W'(evict);
                if (!window_full)
                begin
                    count_next = count_reg + 1'b1;
                end
                slot_next    = (slot_inc == NW'(cfg.window)) ? '0 : RIDX_W'(slot_inc);
                div_next     = sum_next;
                rem_next     = '0;
                div_cnt_next = '0;
            end
            ftma_pkg::B_DIV:
            begin
                rem_next     = rem_ge ? ftma_pkg::CNT_W'(rem_sh - {1'b0, count_reg})
                                      : rem_sh[ftma_pkg::CNT_W-1:0];
                div_next     = {div_reg[ftma_pkg::SUM_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    avg_next = div_next[ftma_pkg::TIME_W-1:0];
                end
            end
            default:
            begin
                div_cnt_next = div_cnt_reg;
            end
        endcase

        // window_length write, to be made only while idle; the block itself does not enforce this
        if (cfg.window_clear)
        begin
            sum_next   = '0;
            count_next = '0;
            slot_next  = '0;
            avg_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftma_pkg::B_IDLE;
            last_time_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        delta_reg   <= delta_next;
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_time_reg   <= last_time_reg;
            out_avg_reg    <= avg_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.frame_time_ns = out_time_reg;
    assign rsp.average_ns    = out_avg_reg;
    assign rsp.sample_count  = out_count_reg;

    a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cfg.window)
        else $error("sample count above window length");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftma_pkg::B_DIV) |-> (count_reg != '0))
        else $error("average divider started with zero count");

    a_push_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftma_pkg::B_PUSH) |=> (state_reg == ftma_pkg::B_DIV))
        else $error("sample push not followed by averaging");

endmodule

`default_nettype wire

// ----- rtl/core/frame_timer_moving_average_unit.sv -----
// Frame timer with a sliding-window moving average of frame durations in ns.
// A mark transaction sets a slot's written flag; a read transaction with a ready
// query converts the tick difference to ns (Q16.16 period, rounded, saturating at
// 40 bits), pushes it into the window ring and clears the flag. Every command gives
// one result: status, last frame time, window average and sample count. Commands
// other than a taken sample go straight to the result register; a taken sample
// passes the multiplier, conversion and ring push, then the serial divider that
// forms the average one quotient bit a cycle over the 47-bit window sum. A two-entry
// queue lets marks and rejected reads be accepted while a sample is being averaged.
// Configuration writes are expected only while no command is in flight.
`default_nettype none

module frame_timer_moving_average_unit #(
    parameter int MAX_FRAMES = 8,
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ftma_req_if.sink                               req,
    ftma_rsp_if.source                             rsp,
    input  wire logic                              cfg_we,
    input  wire logic [ftma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ftma_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [ftma_pkg::FIF_W-1:0]     fif_reg;
    logic [ftma_pkg::CNT_W-1:0]     wlen_reg;
    logic [ftma_pkg::PERIOD_W-1:0]  period_reg;
    logic [ftma_pkg::CNT_W-1:0]     window_used;
    ftma_pkg::cfg_t                 cfg;
    logic                           q_push_valid;
    logic                           q_push_ready;
    ftma_pkg::q_item_t              q_push_item;
    logic                           q_pop_valid;
    logic                           q_pop_ready;
    ftma_pkg::q_item_t              q_pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fif_reg    <= ftma_pkg::FIF_W'(2);
            wlen_reg   <= ftma_pkg::CNT_W'(64);
            period_reg <= ftma_pkg::PERIOD_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ftma_pkg::CFG_FRAMES: fif_reg    <= cfg_data[ftma_pkg::FIF_W-1:0];
                ftma_pkg::CFG_WINDOW: wlen_reg   <= cfg_data[ftma_pkg::CNT_W-1:0];
                ftma_pkg::CFG_PERIOD: period_reg <= cfg_data[ftma_pkg::PERIOD_W-1:0];
                default:
                begin
                    fif_reg <= fif_reg;
                end
            endcase
        end
    end

    // window clamped to one..MAX_WINDOW
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            window_used = ftma_pkg::CNT_W'(1);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            window_used = ftma_pkg::CNT_W'(MAX_WINDOW);
        end
        else
        begin
            window_used = wlen_reg;
        end
    end

    assign cfg.fif          = fif_reg;
    assign cfg.window       = window_used;
    assign cfg.period       = period_reg;
    assign cfg.window_clear = cfg_we && (cfg_index == ftma_pkg::CFG_WINDOW);

    ftma_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    ftma_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    ftma_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_item  (q_pop_item),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- tb/tb_frame_timer_moving_average_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the frame timer moving average unit: directed and random
// command traffic, an in-line prediction of each result and a field-by-field check.
// Depends on ftma_pkg, the ftma_req_if / ftma_rsp_if channel interfaces and the unit.

module tb_frame_timer_moving_average_unit;

    import ftma_pkg::*;

    localparam int          SLOT_COUNT     = 8;
    localparam int          RING_DEPTH     = 64;
    localparam int          RESET_CYCLES   = 5;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          TAIL_CYCLES    = 64;
    localparam int          HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int          CHUNKS         = 4;
    localparam int          CHUNK_ITEMS    = 107;

    typedef struct {
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic [TICK_W-1:0] start_ticks;
        logic [TICK_W-1:0] end_ticks;
        logic [QS_W-1:0]   qs;
    } frame_cmd_t;

    typedef struct {
        status_t           status;
        logic [TIME_W-1:0] frame_ns;
        logic [TIME_W-1:0] avg_ns;
        logic [CNT_W-1:0]  count;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ftma_req_if cmd_chan ();
    ftma_rsp_if res_chan ();

    frame_timer_moving_average_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (cmd_chan),
        .rsp       (res_chan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted block state
    logic [FIF_W-1:0]    cfg_frames;
    logic [CNT_W-1:0]    cfg_window;
    logic [PERIOD_W-1:0] cfg_period;
    logic                slot_marked [SLOT_COUNT];
    logic [TIME_W-1:0]   window_ring [RING_DEPTH];
    logic [63:0]         window_total;
    int unsigned         ring_head;
    int unsigned         ring_fill;
    logic [TIME_W-1:0]   last_frame_ns;

    frame_result_t       expected_results [$];
    int unsigned         fail_count;
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    bit                  hold_request;
    int unsigned         hold_left;
    int unsigned         quiet_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned slots_in_use();
        return (cfg_frames < SLOT_COUNT) ? cfg_frames : SLOT_COUNT;
    endfunction

    function automatic int unsigned window_in_use();
        if (cfg_window == 0)
            return 1;
        return (cfg_window < RING_DEPTH) ? cfg_window : RING_DEPTH;
    endfunction

    // exact product, round half up, saturate at the time width
    function automatic logic [TIME_W-1:0] ticks_to_ns(logic [TICK_W-1:0] delta,
                                                      logic [PERIOD_W-1:0] period);
        logic [96:0] scaled;
        scaled = {33'd0, delta} * {65'd0, period};
        scaled = (scaled + 97'd32768) >> FRAC_W;
        if (|scaled[96:TIME_W])
            return TIME_MAX;
        return scaled[TIME_W-1:0];
    endfunction

    function automatic void push_sample(logic [TIME_W-1:0] ns);
        int unsigned w;
        w = window_in_use();
        if (ring_head >= w)
            ring_head = 0;
        if (ring_fill < w)
            ring_fill++;
        else
            window_total -= window_ring[ring_head];
        window_ring[ring_head] = ns;
        window_total += ns;
        ring_head = (ring_head + 1) % w;
    endfunction

    function automatic frame_result_t predict_result(frame_cmd_t c);
        frame_result_t r;
        if (c.idx >= slots_in_use())
            r.status = ST_BAD_INDEX;
        else if (c.cmd == CMD_MARK)
        begin
            slot_marked[c.idx] = 1'b1;
            r.status = ST_MARKED;
        end
        else if (!slot_marked[c.idx])
            r.status = ST_UNWRITTEN;
        else if (c.qs == QS_NOT_READY)
            r.status = ST_NOT_READY;
        else if (c.qs != QS_READY)
            r.status = ST_FAILED;
        else
        begin
            last_frame_ns = ticks_to_ns(c.end_ticks - c.start_ticks, cfg_period);
            push_sample(last_frame_ns);
            slot_marked[c.idx] = 1'b0;
            r.status = ST_SAMPLE;
        end
        r.frame_ns = last_frame_ns;
        r.avg_ns   = (ring_fill == 0) ? '0 : TIME_W'(window_total / ring_fill);
        r.count    = CNT_W'(ring_fill);
        return r;
    endfunction

    function automatic void apply_config(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        case (r)
            CFG_FRAMES: cfg_frames = v[FIF_W-1:0];
            CFG_WINDOW:
            begin
                cfg_window   = v[CNT_W-1:0];
                window_total = '0;
                ring_head    = 0;
                ring_fill    = 0;
            end
            CFG_PERIOD: cfg_period = v;
            default: ;
        endcase
    endfunction

    task automatic send_cmd(frame_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_chan.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_chan.valid       <= 1'b1;
        cmd_chan.cmd         <= c.cmd;
        cmd_chan.frame_index <= c.idx;
        cmd_chan.start_ticks <= c.start_ticks;
        cmd_chan.end_ticks   <= c.end_ticks;
        cmd_chan.query_state <= c.qs;
        @(posedge clk);
        while (!cmd_chan.ready)
            @(posedge clk);
        expected_results.push_back(predict_result(c));
        @(negedge clk);
    endtask

    task automatic send_mark(int unsigned idx);
        frame_cmd_t c;
        c.cmd         = CMD_MARK;
        c.idx         = IDX_W'(idx);
        c.start_ticks = {$urandom, $urandom};
        c.end_ticks   = {$urandom, $urandom};
        c.qs          = QS_W'($urandom_range(3));
        send_cmd(c);
    endtask

    task automatic send_read(int unsigned idx, logic [QS_W-1:0] qs,
                             logic [TICK_W-1:0] start_ticks, logic [TICK_W-1:0] end_ticks);
        frame_cmd_t c;
        c.cmd         = CMD_READ;
        c.idx         = IDX_W'(idx);
        c.start_ticks = start_ticks;
        c.end_ticks   = end_ticks;
        c.qs          = qs;
        send_cmd(c);
    endtask

    // sender pauses until every outstanding result has come back
    task automatic drain();
        cmd_chan.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        apply_config(r, v);
        @(negedge clk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] frames, logic [CFG_DATA_W-1:0] window,
                              logic [CFG_DATA_W-1:0] period, bit touch_window);
        drain();
        write_reg(CFG_FRAMES, frames);
        write_reg(CFG_PERIOD, period);
        if (touch_window)
            write_reg(CFG_WINDOW, window);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic frame_cmd_t random_cmd();
        frame_cmd_t  c;
        int unsigned pick;
        int unsigned slots;
        int unsigned marked [$];
        pick  = $urandom_range(99);
        slots = slots_in_use();
        for (int i = 0; i < slots; i++)
            if (slot_marked[i])
                marked.push_back(i);
        c.start_ticks = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3: c.end_ticks = c.start_ticks + $urandom_range(200000);
            4, 5, 6:    c.end_ticks = c.start_ticks + {32'd0, $urandom};
            7, 8:       c.end_ticks = {$urandom, $urandom};
            default:    c.end_ticks = c.start_ticks - $urandom_range(1000);
        endcase
        c.idx = (slots == 0) ? IDX_W'($urandom_range(7)) : IDX_W'($urandom_range(slots - 1));
        c.qs  = ($urandom_range(99) < 75) ? QS_READY : QS_W'($urandom_range(1, 3));
        if (pick < 40)
            c.cmd = CMD_MARK;
        else if (pick < 88)
        begin
            c.cmd = CMD_READ;
            if (marked.size() != 0 && $urandom_range(99) < 85)
                c.idx = IDX_W'(marked[$urandom_range(marked.size() - 1)]);
        end
        else
        begin
            // noise: any slot, any query code
            c.cmd = cmd_t'($urandom_range(1));
            c.idx = IDX_W'($urandom_range(7));
            c.qs  = QS_W'($urandom_range(3));
        end
        return c;
    endfunction

    task automatic randomise_config(bit touch_window);
        logic [FIF_W-1:0]    frames;
        logic [CNT_W-1:0]    window;
        logic [PERIOD_W-1:0] period;
        int unsigned         r;
        r = $urandom_range(99);
        if (r < 70)
            frames = FIF_W'($urandom_range(1, 8));
        else if (r < 85)
            frames = FIF_W'(8);
        else
            frames = FIF_W'($urandom_range(9, 15));
        r = $urandom_range(99);
        if (r < 60)
            window = CNT_W'($urandom_range(1, 12));
        else if (r < 75)
            window = CNT_W'(64);
        else if (r < 85)
            window = CNT_W'($urandom_range(13, 63));
        else if (r < 92)
            window = '0;
        else
            window = CNT_W'($urandom_range(65, 127));
        r = $urandom_range(99);
        if (r < 40)
            period = 32'h0001_0000 + $urandom_range(65535) - 32'd32768;
        else if (r < 70)
            period = $urandom_range(1, 1 << 20);
        else if (r < 85)
            period = $urandom;
        else if (r < 92)
            period = '1;
        else if (r < 96)
            period = '0;
        else
            period = 32'd1;
        // junk above the register widths must be ignored
        set_config(($urandom & ~32'hF) | frames, ($urandom & ~32'h7F) | window, period,
                   touch_window);
    endtask

    task automatic test_status_codes();
        send_read(0, QS_READY, 64'd0, 64'd10);
        send_mark(0);
        send_mark(0);
        send_read(0, QS_NOT_READY, 64'd0, 64'd10);
        send_read(0, QS_FAILED, 64'd0, 64'd10);
        send_read(0, 2'd3, 64'd0, 64'd10);
        send_read(0, QS_READY, 64'd100, 64'd1100);
        send_read(0, QS_READY, 64'd100, 64'd1100);
        send_mark(2);
        send_read(7, QS_READY, 64'd0, 64'd10);
    endtask

    task automatic test_tick_conversion();
        // end before start wraps round and saturates
        send_mark(1);
        send_read(1, QS_READY, 64'd5, 64'd4);
        send_mark(1);
        send_read(1, QS_READY, '0, '1);
        send_mark(0);
        send_read(0, QS_READY, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0);
    endtask

    task automatic test_config_extremes();
        // half a nanosecond per tick: one tick rounds up
        set_config(8, 1, 32'h0000_8000, 1'b1);
        send_mark(7);
        send_read(7, QS_READY, 64'd10, 64'd11);
        set_config(15, 127, 32'hFFFF_FFFF, 1'b1);
        send_mark(5);
        send_read(5, QS_READY, 64'd0, 64'd1);
        send_mark(4);
        send_read(4, QS_READY, 64'd0, 64'h0000_0000_0100_0000);
        set_config(0, 0, 32'd1, 1'b1);
        send_mark(0);
        send_read(0, QS_READY, 64'd0, 64'd10);
        // zero period, window left as it was
        set_config(8, 0, 32'd0, 1'b0);
        send_mark(3);
        send_read(3, QS_READY, 64'd0, '1);
    endtask

    task automatic test_backpressure();
        set_config(8, 4, 32'h0001_0000, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            send_mark(i);
            send_read(i, QS_READY, 64'd1000, 64'd1000 + $urandom_range(5000));
        end
        drain();
    endtask

    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            randomise_config((chunk == 0) || ($urandom_range(3) != 0));
            repeat (CHUNK_ITEMS) send_cmd(random_cmd());
        end
    endtask

    // result sink: ready pattern, with a long hold-off on request
    initial
    begin
        res_chan.ready = 1'b0;
        hold_left      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                res_chan.ready <= 1'b0;
                hold_left--;
            end
            else
                res_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && res_chan.valid && res_chan.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing outstanding, status %0d",
                       res_chan.status);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_chan.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_chan.status);
                    fail_count++;
                end
                if (res_chan.frame_time_ns !== want.frame_ns)
                begin
                    $error("frame_time_ns: expected %0d, got %0d",
                           want.frame_ns, res_chan.frame_time_ns);
                    fail_count++;
                end
                if (res_chan.average_ns !== want.avg_ns)
                begin
                    $error("average_ns: expected %0d, got %0d",
                           want.avg_ns, res_chan.average_ns);
                    fail_count++;
                end
                if (res_chan.sample_count !== want.count)
                begin
                    $error("sample_count: expected %0d, got %0d",
                           want.count, res_chan.sample_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_chan.valid && cmd_chan.ready) || (res_chan.valid && res_chan.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_FRAMES;
        cfg_data             = '0;
        cmd_chan.valid       = 1'b0;
        cmd_chan.cmd         = CMD_MARK;
        cmd_chan.frame_index = '0;
        cmd_chan.start_ticks = '0;
        cmd_chan.end_ticks   = '0;
        cmd_chan.query_state = QS_READY;
        quiet_cycles         = 0;
        fail_count           = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_request         = 1'b0;
        cfg_frames           = FIF_W'(2);
        cfg_window           = CNT_W'(64);
        cfg_period           = 32'h0001_0000;
        window_total         = '0;
        ring_head            = 0;
        ring_fill            = 0;
        last_frame_ns        = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
            slot_marked[i] = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_status_codes();
        test_tick_conversion();
        test_config_extremes();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(51, 0);
        test_random_traffic(0, 51);
        test_random_traffic(8, 8);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
